// ===== rtl/svr_pkg.sv =====
package svr_pkg;

    localparam int SCALE_FRAC = 16;

    localparam logic [63:0] BIAS      = 64'd9223372036854775295;
    localparam logic [63:0] HALF_BIAS = BIAS >> 1;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_ENCODE = 1'b1;

    localparam logic [2:0] CFG_SCALE      = 3'd0;
    localparam logic [2:0] CFG_ACTIVE     = 3'd1;
    localparam logic [2:0] CFG_EXT_LIMBS  = 3'd2;
    localparam logic [2:0] CFG_EXT_ENABLE = 3'd3;
    localparam logic [2:0] CFG_LOG_DEGREE = 3'd4;
    localparam logic [2:0] CFG_LOG_SLOTS  = 3'd5;

    typedef struct packed {
        logic [62:0] modulus;
        logic [62:0] difference;
        logic [63:0] ratio;
        logic [6:0]  shift;
    } limb_entry_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [62:0] divisor;
    } rem_req_t;

    typedef struct packed {
        logic        done;
        logic [62:0] remainder;
    } rem_rsp_t;

endpackage

// ===== rtl/svr_rem.sv =====
// Bit-serial restoring remainder, one dividend bit per cycle.
module svr_rem (
    input  logic               clk,
    input  logic               rst_n,
    input  svr_pkg::rem_req_t  req,
    output svr_pkg::rem_rsp_t  rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  count_reg, count_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] x_reg, x_next;
    logic [62:0] p_reg, p_next;
    logic [64:0] trial;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        trial      = {rem_reg, x_reg[63]};
        if (trial >= {2'b00, p_reg})
        begin
            trial = trial - {2'b00, p_reg};
        end
        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = 6'd63;
            rem_next   = 64'd0;
            x_next     = req.dividend;
            p_next     = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = trial[63:0];
            x_next     = {x_reg[62:0], 1'b0};
            count_next = count_reg - 6'd1;
            if (count_reg == 6'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= 6'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        x_reg   <= x_next;
        p_reg   <= p_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg[62:0];

endmodule

// ===== rtl/scaled_value_to_rns_residues_core.sv =====
// Load beat: written to the limb memory in the accepting cycle, no result.
// Encode beat: each part is scaled in 4 partial products and 2 finish steps; then per
// limb the entry is read, and per residue a setup, 64 steps of the bit-serial remainder
// unit and an output step that waits for a free output register follow; the next beat is
// taken after the last residue is output. Output beats sit in a register.
// rst_n clears control and config registers; the limb memory is not cleared.
module scaled_value_to_rns_residues_core #(
    parameter int MAX_LIMBS      = 32,
    parameter int MAX_LOG_DEGREE = 16,
    parameter int FRACTION_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [61:0]         cfg_data,
    // input beats
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [4:0]          limb_index,
    input  logic [62:0]         prime_modulus,
    input  logic [62:0]         offset_difference,
    input  logic [63:0]         reduction_ratio,
    input  logic [6:0]          reduction_shift,
    input  logic [14:0]         slot_index,
    input  logic signed [47:0]  real_part,
    input  logic signed [47:0]  imag_part,
    // result beats
    output logic                out_valid,
    input  logic                out_ready,
    output logic [4:0]          limb,
    output logic [15:0]         position,
    output logic [62:0]         residue,
    output logic                last
);

    localparam int AW = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
    // product of 48-bit magnitude and 62-bit scale
    localparam int PW = 110;
    localparam int SH = FRACTION_BITS + svr_pkg::SCALE_FRAC;
    localparam logic [PW:0] ROUND_ADD = (PW + 1)'(1) << (SH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SAT   = 3'd2;
    localparam logic [2:0] ST_BIAS  = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_SETUP = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    // configuration registers
    logic [61:0] scale_reg;
    logic [5:0]  active_reg;
    logic [4:0]  ext_limbs_reg;
    logic        ext_en_reg;
    logic [4:0]  log_deg_reg;
    logic [3:0]  log_slots_reg;

    // control
    logic [2:0]  state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        part_reg, part_next;
    logic [4:0]  limb_reg, limb_next;
    logic [5:0]  total_reg, total_next;

    // payload
    logic [47:0]   imag_reg;
    logic [47:0]   mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [PW-1:0] acc_reg, acc_next;
    logic [63:0]   m_reg, m_next;
    logic [63:0]   vr_reg, vi_reg, v_next;
    logic          big_r_reg, big_i_reg, big_next;
    logic [15:0]   pos_re_reg, pos_im_reg;
    logic          rneg_reg, rneg_next;

    // limb memory
    svr_pkg::limb_entry_t limb_mem [MAX_LIMBS];
    svr_pkg::limb_entry_t mem_q_reg;
    svr_pkg::limb_entry_t wr_entry;
    logic                 mem_we;
    logic                 mem_re;

    // output register
    logic        out_valid_reg;
    logic [4:0]  out_limb_reg;
    logic [15:0] out_pos_reg;
    logic [62:0] out_res_reg;
    logic        out_last_reg;
    logic        out_load;
    logic [62:0] res_final;
    logic        is_last;

    svr_pkg::rem_req_t rem_req;
    svr_pkg::rem_rsp_t rem_rsp;

    // combinational helpers
    logic        in_take;
    logic [4:0]  lg;
    logic [3:0]  ls;
    logic [4:0]  gap_sh;
    logic [14:0] slot_mask;
    logic [15:0] s_lo;
    logic [15:0] slots;
    logic [31:0] pos_re_w, pos_im_w;
    logic [6:0]  total_sum;
    logic [63:0] scale_ext;
    logic [15:0] scale_chunk;
    logic [63:0] pp;
    logic [PW:0] rsum;
    logic [PW:0] q;
    logic [63:0] cap;
    logic [63:0] v_cur;
    logic        big_cur;
    logic [62:0] d_cur;
    logic [63:0] x_cur;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_take   = in_valid && in_ready;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= 62'd0;
            active_reg    <= 6'd1;
            ext_limbs_reg <= 5'd0;
            ext_en_reg    <= 1'b0;
            log_deg_reg   <= 5'd16;
            log_slots_reg <= 4'd15;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                svr_pkg::CFG_SCALE:      scale_reg     <= cfg_data;
                svr_pkg::CFG_ACTIVE:     active_reg    <= cfg_data[5:0];
                svr_pkg::CFG_EXT_LIMBS:  ext_limbs_reg <= cfg_data[4:0];
                svr_pkg::CFG_EXT_ENABLE: ext_en_reg    <= cfg_data[0];
                svr_pkg::CFG_LOG_DEGREE: log_deg_reg   <= cfg_data[4:0];
                svr_pkg::CFG_LOG_SLOTS:  log_slots_reg <= cfg_data[3:0];
                default:                 ;
            endcase
        end
    end

    // slot placement, clamped ring and slot sizes
    always_comb
    begin
        if (log_deg_reg == 5'd0)
            lg = 5'd1;
        else if (32'(log_deg_reg) > MAX_LOG_DEGREE)
            lg = 5'(MAX_LOG_DEGREE);
        else
            lg = log_deg_reg;
        if ({1'b0, log_slots_reg} > lg - 5'd1)
            ls = 4'(lg - 5'd1);
        else
            ls = log_slots_reg;
        gap_sh    = lg - 5'd1 - {1'b0, ls};
        slot_mask = 15'((16'd1 << ls) - 16'd1);
        slots     = 16'd1 << ls;
        s_lo      = {1'b0, slot_index & slot_mask};
        pos_re_w  = {16'd0, s_lo} << gap_sh;
        pos_im_w  = {16'd0, s_lo + slots} << gap_sh;
        total_sum = {1'b0, active_reg} + (ext_en_reg ? {2'b00, ext_limbs_reg} : 7'd0);
    end

    // scaling datapath
    always_comb
    begin
        scale_ext   = {2'b00, scale_reg};
        scale_chunk = scale_ext[{cnt_reg, 4'd0} +: 16];
        pp          = 64'(mag_reg * scale_chunk);
        rsum        = {1'b0, acc_reg} + ROUND_ADD;
        q           = rsum >> SH;
        cap         = neg_reg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        if (!neg_reg || m_reg == 64'd0)
        begin
            v_next   = m_reg;
            big_next = m_reg > svr_pkg::HALF_BIAS;
        end
        else
        begin
            v_next   = svr_pkg::BIAS - m_reg;
            big_next = (m_reg <= svr_pkg::BIAS) && (v_next > svr_pkg::HALF_BIAS);
        end
    end

    // residue setup: reduce v, or |v - d| when v is big, then negate modulo p if v < d
    always_comb
    begin
        v_cur   = part_reg ? vi_reg : vr_reg;
        big_cur = part_reg ? big_i_reg : big_r_reg;
        d_cur   = mem_q_reg.difference;
        if (!big_cur)
        begin
            x_cur     = v_cur;
            rneg_next = 1'b0;
        end
        else if (v_cur >= {1'b0, d_cur})
        begin
            x_cur     = v_cur - {1'b0, d_cur};
            rneg_next = 1'b0;
        end
        else
        begin
            x_cur     = {1'b0, d_cur} - v_cur;
            rneg_next = 1'b1;
        end
        rem_req.start    = (state_reg == ST_SETUP);
        rem_req.dividend = x_cur;
        rem_req.divisor  = mem_q_reg.modulus;

        if (mem_q_reg.modulus < 63'd2)
            res_final = 63'd0;
        else if (rneg_reg && rem_rsp.remainder != 63'd0)
            res_final = mem_q_reg.modulus - rem_rsp.remainder;
        else
            res_final = rem_rsp.remainder;
        is_last = part_reg && ({1'b0, limb_reg} + 6'd1 == total_reg);
    end

    svr_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        part_next  = part_reg;
        limb_next  = limb_reg;
        total_next = total_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        m_next     = m_reg;
        mem_re     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && op == svr_pkg::OP_ENCODE)
                begin
                    neg_next   = real_part[47];
                    mag_next   = real_part[47] ? 48'(-real_part) : real_part;
                    acc_next   = '0;
                    cnt_next   = 2'd3;
                    part_next  = 1'b0;
                    total_next = (32'(total_sum) > MAX_LIMBS) ? 6'(MAX_LIMBS)
                                                              : total_sum[5:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                acc_next = (acc_reg << 16) + {46'd0, pp};
                cnt_next = cnt_reg - 2'd1;
                if (cnt_reg == 2'd0)
                    state_next = ST_SAT;
            end
            ST_SAT:
            begin
                m_next     = (q > {47'd0, cap}) ? cap : q[63:0];
                state_next = ST_BIAS;
            end
            ST_BIAS:
            begin
                if (!part_reg)
                begin
                    part_next  = 1'b1;
                    neg_next   = imag_reg[47];
                    mag_next   = imag_reg[47] ? 48'(-imag_reg) : imag_reg;
                    acc_next   = '0;
                    cnt_next   = 2'd3;
                    state_next = ST_MUL;
                end
                else if (total_reg == 6'd0)
                    state_next = ST_IDLE;
                else
                begin
                    part_next  = 1'b0;
                    limb_next  = 5'd0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (rem_rsp.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load = 1'b1;
                    if (!part_reg)
                    begin
                        part_next  = 1'b1;
                        state_next = ST_SETUP;
                    end
                    else if (is_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        part_next  = 1'b0;
                        limb_next  = limb_reg + 5'd1;
                        state_next = ST_READ;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 2'd0;
            part_reg      <= 1'b0;
            limb_reg      <= 5'd0;
            total_reg     <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            part_reg  <= part_next;
            limb_reg  <= limb_next;
            total_reg <= total_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        m_reg   <= m_next;
        if (in_take)
        begin
            imag_reg   <= imag_part;
            pos_re_reg <= pos_re_w[15:0];
            pos_im_reg <= pos_im_w[15:0];
        end
        if (state_reg == ST_BIAS)
        begin
            if (part_reg)
            begin
                vi_reg    <= v_next;
                big_i_reg <= big_next;
            end
            else
            begin
                vr_reg    <= v_next;
                big_r_reg <= big_next;
            end
        end
        if (state_reg == ST_SETUP)
            rneg_reg <= rneg_next;
        if (out_load)
        begin
            out_limb_reg <= limb_reg;
            out_pos_reg  <= part_reg ? pos_im_reg : pos_re_reg;
            out_res_reg  <= res_final;
            out_last_reg <= is_last;
        end
    end

    // limb memory: one write port for load beats, one registered read port
    assign wr_entry.modulus    = prime_modulus;
    assign wr_entry.difference = offset_difference;
    assign wr_entry.ratio      = reduction_ratio;
    assign wr_entry.shift      = reduction_shift;
    assign mem_we = in_take && (op == svr_pkg::OP_LOAD) && (32'(limb_index) < MAX_LIMBS);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            limb_mem[limb_index[AW-1:0]] <= wr_entry;
        if (mem_re)
            mem_q_reg <= limb_mem[limb_reg[AW-1:0]];
    end

    assign out_valid = out_valid_reg;
    assign limb      = out_limb_reg;
    assign position  = out_pos_reg;
    assign residue   = out_res_reg;
    assign last      = out_last_reg;

endmodule
